// File: rtl/mmnb_pkg.sv
// Shared types and constants for the min/max normalize-to-byte block.
package mmnb_pkg;

  // Parameter defaults
  localparam int FRAME_DEPTH_DEF = 4096;
  localparam int SAMPLE_BITS_DEF = 24;

  // Request and result field widths
  localparam int MODE_W      = 2;
  localparam int INDEX_W     = 12;
  localparam int IN_SAMPLE_W = 24;
  localparam int PIXEL_W     = 8;

  // Stream data widths, padded to whole bytes
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 8;

  localparam logic [PIXEL_W-1:0] PIXEL_MAX = {PIXEL_W{1'b1}};

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MEM,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

// File: rtl/mmnb_div.sv
// Radix-2 restoring divider giving an 8-bit fraction quotient (dividend < divisor).
module mmnb_div #(
  parameter int DW = mmnb_pkg::SAMPLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [DW-1:0]               dividend,
  input  logic [DW-1:0]               divisor,
  output logic                        done,
  output logic [mmnb_pkg::PIXEL_W-1:0] quotient
);

  localparam int CNT_W = $clog2(mmnb_pkg::PIXEL_W + 1);

  logic [DW-1:0]    rem;
  logic [DW-1:0]    dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DW:0]      shifted;
  logic [DW:0]      trial;
  logic             ge;

  assign shifted = {rem, 1'b0};
  assign ge      = (shifted >= {1'b0, dvs});
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(mmnb_pkg::PIXEL_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // one quotient bit per cycle, MSB first
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dvs      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= ge ? trial[DW-1:0] : shifted[DW-1:0];
      quotient <= {quotient[mmnb_pkg::PIXEL_W-2:0], ge};
    end
  end

endmodule

// File: rtl/min_max_normalize_to_byte_core.sv
// Top level of the min/max normalize-to-byte block: sample store, bounds, read sequencer.
//
// Keeps a frame of signed fixed-point height samples (Q15.8 at the default
// SAMPLE_BITS of 24) in a single-port synchronous RAM, plus a running minimum
// and maximum. A clear request zeroes both bounds; a load request writes one
// sample and widens the bounds; a read request returns
// floor((sample - min) * 256 / (max - min)) clamped to 0..255, or 0 when the
// range is empty or the index lies past the store. Clear, load and unused
// mode 3 leave the sequencer in idle and produce no result. A read goes, from
// its acceptance to the next acceptance, through the registered RAM read, the
// offset, span and clamp checks, the radix-2 divider (eight quotient bits),
// the capture of the quotient, the load of the output register and the
// return to idle. Reads that clamp or hit an empty range skip the divider.
// A read also waits in its last step while an earlier pixel still sits in
// the output register. The output register lets the next request in while
// a pixel waits on m_tready.
// Store entries have no reset; reading one never written is undefined.
module min_max_normalize_to_byte_core #(
  parameter int FRAME_DEPTH = mmnb_pkg::FRAME_DEPTH_DEF,
  parameter int SAMPLE_BITS = mmnb_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [11:0] index, [35:12] sample, [39:36] zero
  input  logic [mmnb_pkg::S_TDATA_W-1:0] s_tdata,
  // [1:0] mode
  input  logic [mmnb_pkg::MODE_W-1:0]    s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [7:0] pixel
  output logic [mmnb_pkg::M_TDATA_W-1:0] m_tdata
);

  localparam int ADDR_W = $clog2(FRAME_DEPTH);
  localparam int SB     = SAMPLE_BITS;

  mmnb_pkg::state_t state, state_next;

  // request fields
  logic [mmnb_pkg::INDEX_W-1:0]            in_index;
  logic signed [mmnb_pkg::IN_SAMPLE_W-1:0] in_sample;
  logic signed [SB-1:0]                    sample_w;
  logic [ADDR_W-1:0]                       addr;
  logic                                    in_range;
  logic                                    accept;

  // sample store
  logic [SB-1:0] store [FRAME_DEPTH];
  logic [SB-1:0] rd_data;
  logic          rd_ok;

  // bounds
  logic signed [SB-1:0] range_low;
  logic signed [SB-1:0] range_high;

  // normalize datapath
  logic signed [SB:0]            diff;
  logic signed [SB:0]            span;
  logic                          span_empty;
  logic                          diff_pos;
  logic                          diff_over;
  logic                          div_start;
  logic                          div_done;
  logic [mmnb_pkg::PIXEL_W-1:0]  div_quot;
  logic [mmnb_pkg::PIXEL_W-1:0]  result;
  logic                          out_load;

  assign in_index  = s_tdata[mmnb_pkg::INDEX_W-1:0];
  assign in_sample = s_tdata[mmnb_pkg::INDEX_W +: mmnb_pkg::IN_SAMPLE_W];
  // sign-extends or wraps to the store width
  assign sample_w  = SB'(in_sample);
  assign addr      = ADDR_W'(in_index);
  assign in_range  = (int'(in_index) < FRAME_DEPTH);
  assign accept    = s_tvalid && s_tready;

  // offset and span, one bit wider so neither can overflow
  assign diff       = {rd_data[SB-1], rd_data} - {range_low[SB-1], range_low};
  assign span       = {range_high[SB-1], range_high} - {range_low[SB-1], range_low};
  assign span_empty = (span <= 0);
  assign diff_pos   = (diff > 0);
  assign diff_over  = (diff >= span);   // quotient would reach 256: clamp

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmnb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      mmnb_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && (s_tuser == mmnb_pkg::MODE_READ)) begin
          state_next = mmnb_pkg::ST_MEM;
        end
      end
      mmnb_pkg::ST_MEM: begin
        if (rd_ok && !span_empty && diff_pos && !diff_over) begin
          div_start  = 1'b1;
          state_next = mmnb_pkg::ST_DIV;
        end else begin
          state_next = mmnb_pkg::ST_DONE;
        end
      end
      mmnb_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = mmnb_pkg::ST_DONE;
        end
      end
      mmnb_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = mmnb_pkg::ST_IDLE;
        end
      end
      default: state_next = mmnb_pkg::ST_IDLE;
    endcase
  end

  // ---------------- sample store ----------------
  // One request at a time, so a read never overlaps a write to the same entry.
  always_ff @(posedge clk) begin
    if (accept && (s_tuser == mmnb_pkg::MODE_LOAD) && in_range) begin
      store[addr] <= sample_w;
    end
    if (accept && (s_tuser == mmnb_pkg::MODE_READ)) begin
      rd_data <= store[addr];
      rd_ok   <= in_range;
    end
  end

  // ---------------- bounds ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= '0;
      range_high <= '0;
    end else if (accept) begin
      if (s_tuser == mmnb_pkg::MODE_CLEAR) begin
        range_low  <= '0;
        range_high <= '0;
      end else if ((s_tuser == mmnb_pkg::MODE_LOAD) && in_range) begin
        if (sample_w > range_high) begin
          range_high <= sample_w;
        end
        if (sample_w < range_low) begin
          range_low <= sample_w;
        end
      end
    end
  end

  // ---------------- divider ----------------
  mmnb_div #(
    .DW (SB)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff[SB-1:0]),
    .divisor  (span[SB-1:0]),
    .done     (div_done),
    .quotient (div_quot)
  );

  // early answers: out of range / empty / at or below min -> 0, at or above max -> 255
  always_ff @(posedge clk) begin
    if (state == mmnb_pkg::ST_MEM) begin
      result <= (rd_ok && !span_empty && diff_pos && diff_over) ? mmnb_pkg::PIXEL_MAX : '0;
    end else if ((state == mmnb_pkg::ST_DIV) && div_done) begin
      result <= div_quot;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= mmnb_pkg::M_TDATA_W'(result);
    end
  end

endmodule

// File: rtl/mmnb_check.sv
// Port-level checker for the normalize block, bound to the top level.
module mmnb_check (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [mmnb_pkg::MODE_W-1:0]    s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [mmnb_pkg::M_TDATA_W-1:0] m_tdata
);

  // reset leaves no result pending and the input open
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("output valid or input closed after reset");

  // a stalled pixel holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("pixel dropped or changed under backpressure");

  // a read occupies the sequencer
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == mmnb_pkg::MODE_READ)) |=> !s_tready)
    else $error("input open right after a read request");

  // clear, load and unused mode leave the input open
  a_single_cycle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser != mmnb_pkg::MODE_READ)) |=> s_tready)
    else $error("non-read request did not finish in one cycle");

endmodule

bind min_max_normalize_to_byte_core mmnb_check u_mmnb_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
